>>> src/three_key_press_debouncer_unit_macros.svh
// ----------------------------------------------------------------------------
// Three-key press debouncer assertion macros
// Shared concurrent assertion forms for the debouncer unit.
// ----------------------------------------------------------------------------
`ifndef THREE_KEY_PRESS_DEBOUNCER_UNIT_MACROS_SVH
`define THREE_KEY_PRESS_DEBOUNCER_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define TKPD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("tkpd assertion failed");

// Next-cycle implication, disabled during reset
`define TKPD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("tkpd assertion failed");

`endif

>>> src/tkpd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Three-key press debouncer package
// Phase codes, configuration layout and result types.
// ----------------------------------------------------------------------------
package tkpd_pkg;

	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 1;

	localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_TICKS   = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS_TICKS = 1'b1;

	localparam logic [CFG_W-1:0] DEBOUNCE_TICKS_RST   = 16'd20;
	localparam logic [CFG_W-1:0] LONG_PRESS_TICKS_RST = 16'd1000;

	typedef enum logic [1:0] {
		PH_IDLE    = 2'd0,
		PH_PRESS   = 2'd1,
		PH_HELD    = 2'd2,
		PH_RELEASE = 2'd3
	} phase_t;

	typedef struct packed {
		logic [CFG_W-1:0] debounce_ticks;
		logic [CFG_W-1:0] long_press_ticks;
	} cfg_t;

	typedef struct packed {
		logic start;
		logic stop;
		logic clear;
	} pulse_t;

endpackage

>>> src/three_key_press_debouncer_unit.sv
// The result of an accepted request is registered in the output register, or in the skid when the output is stalled.
// Throughput: one request per cycle while in_stall is low; key state updates in a single pass per request.
// A two-entry output buffer (output register plus skid) keeps input open under output stall until the skid fills.
// Reset: arst_n clears all key phases and counters and empties the output buffer;
// debounce_ticks returns to 20 and long_press_ticks to 1000.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Three-key press debouncer unit
// Start/stop short-press keys and a clear key with long-press detection.
// ----------------------------------------------------------------------------
`include "three_key_press_debouncer_unit_macros.svh"

module three_key_press_debouncer_unit import tkpd_pkg::*; #(
	parameter int COUNT_WIDTH = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 start_key_level,
	input  logic                 stop_key_level,
	input  logic                 clear_key_level,
	input  logic                 fault_present,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic                 start_pulse,
	output logic                 stop_pulse,
	output logic                 clear_faults_pulse
);

	cfg_t   cfg_q;
	pulse_t new_pulse;
	pulse_t main_q, skid_q;
	logic   main_vld_q, skid_vld_q;
	logic   acc, take;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ticks   <= DEBOUNCE_TICKS_RST;
			cfg_q.long_press_ticks <= LONG_PRESS_TICKS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_DEBOUNCE_TICKS:   cfg_q.debounce_ticks   <= cfg_data;
				CFG_LONG_PRESS_TICKS: cfg_q.long_press_ticks <= cfg_data;
				default: ;
			endcase
		end
	end

	assign in_stall = skid_vld_q;
	assign acc      = in_valid && !skid_vld_q;
	assign take     = main_vld_q && !out_stall;

	tkpd_short_key #(.COUNT_WIDTH(COUNT_WIDTH)) u_start_key (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (acc),
		.pressed (!start_key_level),
		.cfg     (cfg_q),
		.pulse   (new_pulse.start)
	);

	tkpd_short_key #(.COUNT_WIDTH(COUNT_WIDTH)) u_stop_key (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (acc),
		.pressed (!stop_key_level),
		.cfg     (cfg_q),
		.pulse   (new_pulse.stop)
	);

	tkpd_long_key #(.COUNT_WIDTH(COUNT_WIDTH)) u_clear_key (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (acc),
		.pressed (!clear_key_level),
		.fault   (fault_present),
		.cfg     (cfg_q),
		.pulse   (new_pulse.clear)
	);

	// output register and skid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_vld_q <= 1'b0;
			skid_vld_q <= 1'b0;
		end else begin
			if (!main_vld_q || take) begin
				main_vld_q <= skid_vld_q || acc;
				skid_vld_q <= 1'b0;
			end else if (acc) begin
				skid_vld_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!main_vld_q || take) begin
			main_q <= skid_vld_q ? skid_q : new_pulse;
		end
		if (acc && main_vld_q && !take) begin
			skid_q <= new_pulse;
		end
	end

	assign out_valid          = main_vld_q;
	assign start_pulse        = main_q.start;
	assign stop_pulse         = main_q.stop;
	assign clear_faults_pulse = main_q.clear;

	`TKPD_ASSERT_NOW(a_skid_needs_main, clk, arst_n, skid_vld_q, main_vld_q)
	`TKPD_ASSERT_NEXT(a_stalled_accept_to_skid, clk, arst_n, acc && main_vld_q && out_stall, skid_vld_q)
	`TKPD_ASSERT_NEXT(a_skid_drains, clk, arst_n, take && skid_vld_q, main_vld_q && !skid_vld_q)
	`TKPD_ASSERT_NEXT(a_accept_fills_out, clk, arst_n, acc, main_vld_q)

endmodule

>>> src/tkpd_short_key.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Short-press key debouncer
// Four-phase press/release debouncer; pulses when a release qualifies.
// ----------------------------------------------------------------------------
module tkpd_short_key import tkpd_pkg::*; #(
	parameter int COUNT_WIDTH = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic pressed,
	input  cfg_t cfg,
	output logic pulse
);

	localparam int CMP_W = (COUNT_WIDTH > CFG_W) ? COUNT_WIDTH : CFG_W;

	phase_t                 ph_q, ph_d;
	logic [COUNT_WIDTH-1:0] cnt_q, cnt_d, cnt_inc;
	logic                   reached;

	assign cnt_inc = (cnt_q == {COUNT_WIDTH{1'b1}}) ? cnt_q : cnt_q + COUNT_WIDTH'(1);
	assign reached = CMP_W'(cnt_inc) >= CMP_W'(cfg.debounce_ticks);

	always_comb begin
		ph_d  = ph_q;
		cnt_d = cnt_q;
		case (ph_q)
			PH_IDLE: begin
				if (pressed) begin
					cnt_d = COUNT_WIDTH'(1);
					ph_d  = PH_PRESS;
				end
			end
			PH_PRESS: begin
				if (pressed) begin
					cnt_d = cnt_inc;
					if (reached) ph_d = PH_HELD;
				end else begin
					cnt_d = '0;
					ph_d  = PH_IDLE;
				end
			end
			PH_HELD: begin
				if (!pressed) begin
					cnt_d = COUNT_WIDTH'(1);
					ph_d  = PH_RELEASE;
				end
			end
			PH_RELEASE: begin
				if (!pressed) begin
					cnt_d = cnt_inc;
					if (reached) begin
						cnt_d = '0;
						ph_d  = PH_IDLE;
					end
				end else begin
					cnt_d = '0;
					ph_d  = PH_HELD;
				end
			end
			default: begin
				cnt_d = '0;
				ph_d  = PH_IDLE;
			end
		endcase
	end

	always_comb begin
		pulse = 1'b0;
		case (ph_q)
			PH_RELEASE: pulse = !pressed && reached;
			default:    pulse = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q  <= PH_IDLE;
			cnt_q <= '0;
		end else if (en) begin
			ph_q  <= ph_d;
			cnt_q <= cnt_d;
		end
	end

endmodule

>>> src/tkpd_long_key.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Long-press key debouncer
// Debounces the press, counts hold time, pulses on release of a long press while a fault is present.
// ----------------------------------------------------------------------------
module tkpd_long_key import tkpd_pkg::*; #(
	parameter int COUNT_WIDTH = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic pressed,
	input  logic fault,
	input  cfg_t cfg,
	output logic pulse
);

	localparam int CMP_W = (COUNT_WIDTH > CFG_W) ? COUNT_WIDTH : CFG_W;

	phase_t                 ph_q, ph_d;
	logic [COUNT_WIDTH-1:0] cnt_q, cnt_d, cnt_inc;
	logic                   reached;
	logic                   enough;

	assign cnt_inc = (cnt_q == {COUNT_WIDTH{1'b1}}) ? cnt_q : cnt_q + COUNT_WIDTH'(1);
	assign reached = CMP_W'(cnt_inc) >= CMP_W'(cfg.debounce_ticks);
	assign enough  = CMP_W'(cnt_q) >= CMP_W'(cfg.long_press_ticks);

	always_comb begin
		ph_d  = ph_q;
		cnt_d = cnt_q;
		case (ph_q)
			PH_IDLE: begin
				if (pressed) begin
					cnt_d = COUNT_WIDTH'(1);
					ph_d  = PH_PRESS;
				end
			end
			PH_PRESS: begin
				if (pressed) begin
					cnt_d = cnt_inc;
					if (reached) begin
						cnt_d = '0;
						ph_d  = PH_HELD;
					end
				end else begin
					cnt_d = '0;
					ph_d  = PH_IDLE;
				end
			end
			PH_HELD: begin
				if (pressed) begin
					cnt_d = cnt_inc;
				end else begin
					cnt_d = '0;
					ph_d  = PH_IDLE;
				end
			end
			default: begin
				cnt_d = '0;
				ph_d  = PH_IDLE;
			end
		endcase
	end

	always_comb begin
		pulse = 1'b0;
		case (ph_q)
			PH_HELD: pulse = !pressed && enough && fault;
			default: pulse = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q  <= PH_IDLE;
			cnt_q <= '0;
		end else if (en) begin
			ph_q  <= ph_d;
			cnt_q <= cnt_d;
		end
	end

endmodule
